// ===== rtl/core/frq_pkg.sv =====
// Shared types and constants for the frame ring queue.
// No dependencies; imported by every module of the block.
package frq_pkg;

    // Field widths fixed by the interface
    localparam int LEN_W  = 12;
    localparam int BYTE_W = 8;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 4;
    localparam int SETV_W = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_DROPPED = 2'd1;
    localparam logic [STAT_W-1:0] ST_TRUNC   = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

    // Reset value of the slot limit register
    localparam logic [LEN_W-1:0] SLOT_LIMIT_RST = 12'd2048;

    // Fraction bits of the reciprocal used to reduce set values
    localparam int RECIP_SH = 17;

endpackage

// ===== rtl/core/frq_payload_mem.sv =====
// Payload byte memory: one write port, one read port, registered read data.
// Depends on frq_pkg for the byte width.
module frq_payload_mem #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [frq_pkg::BYTE_W-1:0] wdata,
    input  logic                      re,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [frq_pkg::BYTE_W-1:0] rdata
);
    import frq_pkg::*;

    logic [BYTE_W-1:0] payload_mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // Write byte on push
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            payload_mem[waddr] <= wdata;
        end
    end

    // Read byte into the registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= payload_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/frq_len_store.sv =====
// Slot length store: memory of frame lengths with per-slot valid bits.
// Depends on frq_pkg for the length width. Unwritten slots read as zero.
module frq_len_store #(
    parameter int SLOTS = 16,
    parameter int PTR_W = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      we,
    input  logic [PTR_W-1:0]          waddr,
    input  logic [frq_pkg::LEN_W-1:0] wdata,
    input  logic                      re,
    input  logic [PTR_W-1:0]          raddr,
    output logic [frq_pkg::LEN_W-1:0] rdata
);
    import frq_pkg::*;

    logic [LEN_W-1:0] len_mem [SLOTS];
    logic [SLOTS-1:0] vld_reg;
    logic [SLOTS-1:0] vld_next;
    logic [LEN_W-1:0] rd_data_reg;
    logic             rd_vld_reg;
    logic             rd_vld_next;

    // Mark a slot valid once its length is written
    always_comb
    begin
        vld_next = vld_reg;
        if (we)
        begin
            vld_next[waddr] = 1'b1;
        end
        rd_vld_next = rd_vld_reg;
        if (re)
        begin
            rd_vld_next = vld_reg[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg    <= vld_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    // Write and read the length memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            len_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= len_mem[raddr];
        end
    end

    // Never-written slots read as zero length
    assign rdata = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/core/frame_ring_queue_core.sv =====
// Frame ring queue top level: command sequencer around the length store and payload memory.
// Depends on frq_pkg, frq_len_store and frq_payload_mem.
// Steps: a transferred item passes through S_LEN, then S_DATA loads any result into the
// output register. No new item is taken until S_IDLE, after the chained reads of the
// length store and payload memory; a stalled output holds the sequencer in its last step.
// Reset: pointers, offsets and flags clear, slot_limit returns to 2048, slot lengths read zero.
module frame_ring_queue_core #(
    parameter int SLOTS      = 16,
    parameter int SLOT_BYTES = 2048
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       slot_limit_we,
    input  logic [frq_pkg::LEN_W-1:0]  slot_limit_wdata,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [frq_pkg::CMD_W-1:0]  cmd,
    input  logic [frq_pkg::BYTE_W-1:0] data_byte,
    input  logic                       frame_last,
    input  logic [frq_pkg::LEN_W-1:0]  read_limit,
    input  logic [frq_pkg::SETV_W-1:0] set_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [frq_pkg::BYTE_W-1:0] out_byte,
    output logic                       out_last,
    output logic [frq_pkg::STAT_W-1:0] status,
    output logic [frq_pkg::LEN_W-1:0]  frame_len,
    output logic [frq_pkg::OCC_W-1:0]  occupancy
);
    import frq_pkg::*;

    localparam int PTR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PTR_W1 = PTR_W + 1;
    localparam int DEPTH  = SLOTS * SLOT_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int RECIP  = ((1 << RECIP_SH) + SLOTS - 1) / SLOTS;
    localparam int PROD_W = SETV_W + RECIP_SH;
    localparam int REM_W  = 16;

    localparam logic [PTR_W:0]     SLOTS_P  = PTR_W1'(SLOTS);
    localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(SLOTS - 1);
    localparam logic [LEN_W-1:0]   SB_CAP   =
        (SLOT_BYTES < (1 << LEN_W)) ? LEN_W'(SLOT_BYTES) : '1;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LEN  = 2'd1;
    localparam logic [1:0] S_DATA = 2'd2;

    // Control state
    logic [1:0]        state_reg, state_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [LEN_W-1:0]  wr_off_reg, wr_off_next;
    logic [LEN_W-1:0]  rd_off_reg, rd_off_next;
    logic              dropping_reg, dropping_next;
    logic              truncated_reg, truncated_next;
    logic [LEN_W-1:0]  slot_limit_reg, slot_limit_next;
    logic              out_valid_reg, out_valid_next;

    // Held item and per-step working values
    logic [CMD_W-1:0]  item_cmd_reg;
    logic [BYTE_W-1:0] item_byte_reg;
    logic              item_last_reg;
    logic [LEN_W-1:0]  item_rlim_reg;
    logic [SETV_W-1:0] item_setv_reg;
    logic [SETV_W-1:0] set_quot_reg;
    logic [PTR_W-1:0]  set_ptr_reg, set_ptr_next;
    logic              pop_empty_reg, pop_empty_next;
    logic              pop_fin_reg, pop_fin_next;
    logic [LEN_W-1:0]  pop_idx_reg, pop_idx_next;
    logic [LEN_W-1:0]  pop_len_reg, pop_len_next;

    // Output register
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [LEN_W-1:0]  frame_len_reg, frame_len_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;

    // Memory ports
    logic              len_we, len_re;
    logic [LEN_W-1:0]  len_rdata;
    logic              pay_we, pay_re;
    logic [ADDR_W-1:0] pay_waddr, pay_raddr;
    logic [BYTE_W-1:0] pay_rdata;

    // Combinational working signals
    logic              in_xfer;
    logic              out_free;
    logic              has_res;
    logic              load_out;
    logic [LEN_W-1:0]  lim;
    logic [LEN_W-1:0]  rlim_eff;
    logic [LEN_W-1:0]  n_cnt;
    logic [PTR_W-1:0]  wr_ptr_inc;
    logic              drop_v;
    logic              trunc_v;
    logic [LEN_W-1:0]  wo_v;
    logic [REM_W-1:0]  rem_v;
    logic [PTR_W:0]    sum_v;
    logic [PROD_W-1:0] quot_prod;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [OCC_W-1:0] occ_of(input logic [PTR_W-1:0] w,
                                                 input logic [PTR_W-1:0] r);
        logic [PTR_W:0] diff;
        diff = (w >= r) ? (PTR_W1'(w) - PTR_W1'(r)) : (PTR_W1'(w) + SLOTS_P - PTR_W1'(r));
        occ_of = OCC_W'(diff);
    endfunction

    assign in_xfer   = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign quot_prod = PROD_W'(set_value) * PROD_W'(RECIP);

    // Sequence each item: read length, read payload, then execute
    always_comb
    begin
        state_next      = state_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        wr_off_next     = wr_off_reg;
        rd_off_next     = rd_off_reg;
        dropping_next   = dropping_reg;
        truncated_next  = truncated_reg;
        slot_limit_next = slot_limit_reg;
        out_valid_next  = out_valid_reg;
        set_ptr_next    = set_ptr_reg;
        pop_empty_next  = pop_empty_reg;
        pop_fin_next    = pop_fin_reg;
        pop_idx_next    = pop_idx_reg;
        pop_len_next    = pop_len_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        status_next     = status_reg;
        frame_len_next  = frame_len_reg;
        occ_next        = occ_reg;
        len_we          = 1'b0;
        len_re          = 1'b0;
        pay_we          = 1'b0;
        pay_re          = 1'b0;
        load_out        = 1'b0;
        has_res         = 1'b0;
        drop_v          = 1'b0;
        trunc_v         = truncated_reg;
        wo_v            = wr_off_reg;
        rem_v           = '0;
        sum_v           = '0;
        rlim_eff        = '0;
        n_cnt           = '0;
        pay_raddr       = '0;
        pay_waddr       = ADDR_W'(wr_ptr_reg) * ADDR_W'(SLOT_BYTES) + ADDR_W'(wr_off_reg);
        wr_ptr_inc      = next_slot(wr_ptr_reg);

        // Clamp the slot limit into 1 .. SLOT_BYTES
        lim = (slot_limit_reg == '0) ? LEN_W'(1) : slot_limit_reg;
        if (lim > SB_CAP)
        begin
            lim = SB_CAP;
        end

        // Load the register on a write
        if (slot_limit_we)
        begin
            slot_limit_next = slot_limit_wdata;
        end

        // Release the output register on transfer
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    len_re     = 1'b1;
                    state_next = S_LEN;
                end
            end

            S_LEN:
            begin
                // Pop: bound the byte count and pick the byte index
                rlim_eff = (item_rlim_reg == '0) ? LEN_W'(1) : item_rlim_reg;
                n_cnt    = (rlim_eff < len_rdata) ? rlim_eff : len_rdata;
                if (n_cnt > SB_CAP)
                begin
                    n_cnt = SB_CAP;
                end
                pop_empty_next = (rd_ptr_reg == wr_ptr_reg) || (len_rdata == '0);
                pop_len_next   = len_rdata;
                pop_idx_next   = (rd_off_reg < n_cnt) ? rd_off_reg : n_cnt - 1'b1;
                pop_fin_next   = ((LEN_W + 1)'(pop_idx_next) + 1'b1) >= (LEN_W + 1)'(n_cnt);
                pay_re         = 1'b1;
                pay_raddr      = ADDR_W'(rd_ptr_reg) * ADDR_W'(SLOT_BYTES)
                                 + ADDR_W'(pop_idx_next);

                // Set: finish the remainder and add to the read pointer
                rem_v = REM_W'(item_setv_reg) - REM_W'(set_quot_reg) * REM_W'(SLOTS);
                if (rem_v >= REM_W'(SLOTS))
                begin
                    rem_v = rem_v - REM_W'(SLOTS);
                end
                sum_v = PTR_W1'(rd_ptr_reg) + PTR_W1'(rem_v);
                if (sum_v >= SLOTS_P)
                begin
                    sum_v = sum_v - SLOTS_P;
                end
                set_ptr_next = PTR_W'(sum_v);
                state_next   = S_DATA;
            end

            S_DATA:
            begin
                has_res = (item_cmd_reg == CMD_POP) || (item_cmd_reg == CMD_SET)
                          || ((item_cmd_reg == CMD_PUSH) && item_last_reg);
                if (!has_res || out_free)
                begin
                    state_next = S_IDLE;
                    load_out   = has_res;
                    case (item_cmd_reg)
                        CMD_PUSH:
                        begin
                            // Drop the whole frame if the ring is full at its first byte
                            drop_v = dropping_reg || ((wr_off_reg == '0) && !truncated_reg
                                     && (wr_ptr_inc == rd_ptr_reg));
                            if (!drop_v)
                            begin
                                if (wr_off_reg < lim)
                                begin
                                    pay_we = 1'b1;
                                    wo_v   = wr_off_reg + 1'b1;
                                end
                                else
                                begin
                                    trunc_v = 1'b1;
                                end
                            end
                            out_byte_next = '0;
                            out_last_next = 1'b0;
                            if (!item_last_reg)
                            begin
                                dropping_next  = drop_v;
                                truncated_next = trunc_v;
                                wr_off_next    = wo_v;
                            end
                            else if (drop_v)
                            begin
                                dropping_next  = 1'b0;
                                truncated_next = 1'b0;
                                wr_off_next    = '0;
                                status_next    = ST_DROPPED;
                                frame_len_next = '0;
                            end
                            else
                            begin
                                // Commit length and advance the write pointer
                                len_we         = 1'b1;
                                wr_ptr_next    = wr_ptr_inc;
                                wr_off_next    = '0;
                                truncated_next = 1'b0;
                                dropping_next  = 1'b0;
                                status_next    = trunc_v ? ST_TRUNC : ST_OK;
                                frame_len_next = wo_v;
                            end
                        end

                        CMD_POP:
                        begin
                            if (pop_empty_reg)
                            begin
                                rd_off_next    = '0;
                                out_byte_next  = '0;
                                out_last_next  = 1'b0;
                                status_next    = ST_EMPTY;
                                frame_len_next = '0;
                            end
                            else
                            begin
                                out_byte_next  = pay_rdata;
                                out_last_next  = pop_fin_reg;
                                status_next    = ST_OK;
                                frame_len_next = pop_len_reg;
                                if (pop_fin_reg)
                                begin
                                    rd_ptr_next = next_slot(rd_ptr_reg);
                                    rd_off_next = '0;
                                end
                                else
                                begin
                                    rd_off_next = pop_idx_reg + 1'b1;
                                end
                            end
                        end

                        CMD_SET:
                        begin
                            // Abandon any frame in progress
                            wr_ptr_next    = set_ptr_reg;
                            wr_off_next    = '0;
                            dropping_next  = 1'b0;
                            truncated_next = 1'b0;
                            out_byte_next  = '0;
                            out_last_next  = 1'b0;
                            status_next    = ST_OK;
                            frame_len_next = '0;
                        end

                        default:
                        begin
                            // Unused command: no effect
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Occupancy after the step
        if (load_out)
        begin
            out_valid_next = 1'b1;
            occ_next       = occ_of(wr_ptr_next, rd_ptr_next);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            wr_off_reg     <= '0;
            rd_off_reg     <= '0;
            dropping_reg   <= 1'b0;
            truncated_reg  <= 1'b0;
            slot_limit_reg <= SLOT_LIMIT_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            wr_off_reg     <= wr_off_next;
            rd_off_reg     <= rd_off_next;
            dropping_reg   <= dropping_next;
            truncated_reg  <= truncated_next;
            slot_limit_reg <= slot_limit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: held item, step values, output fields
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_cmd_reg  <= cmd;
            item_byte_reg <= data_byte;
            item_last_reg <= frame_last;
            item_rlim_reg <= read_limit;
            item_setv_reg <= set_value;
            set_quot_reg  <= quot_prod[PROD_W-1:RECIP_SH];
        end
        set_ptr_reg   <= set_ptr_next;
        pop_empty_reg <= pop_empty_next;
        pop_fin_reg   <= pop_fin_next;
        pop_idx_reg   <= pop_idx_next;
        pop_len_reg   <= pop_len_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        status_reg    <= status_next;
        frame_len_reg <= frame_len_next;
        occ_reg       <= occ_next;
    end

    // Slot length store, read at transfer, written at frame commit
    frq_len_store #(
        .SLOTS (SLOTS),
        .PTR_W (PTR_W)
    ) u_len_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (len_we),
        .waddr (wr_ptr_reg),
        .wdata (wo_v),
        .re    (len_re),
        .raddr (rd_ptr_reg),
        .rdata (len_rdata)
    );

    // Payload memory
    frq_payload_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_payload_mem (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (item_byte_reg),
        .re    (pay_re),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign status    = status_reg;
    assign frame_len = frame_len_reg;
    assign occupancy = occ_reg;

    // A transfer always starts the length read step
    a_xfer_to_len: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_LEN))
        else $error("sequencer did not advance after transfer");

    // Pointers stay inside the ring
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (PTR_W1'(rd_ptr_reg) < SLOTS_P) && (PTR_W1'(wr_ptr_reg) < SLOTS_P))
        else $error("ring pointer out of range");

    // A non-empty pop reads inside the stored frame
    a_pop_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DATA) && (item_cmd_reg == CMD_POP) && !pop_empty_reg
        |-> (pop_idx_reg < pop_len_reg))
        else $error("pop index beyond frame length");

    // A result appears only from the execute step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DATA))
        else $error("result loaded outside execute step");

    // Length store is never read and written in the same cycle
    a_len_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(len_we && len_re))
        else $error("length store read and write overlap");

endmodule

// ===== sim/frame_ring_queue_core_tb.sv =====
// Self-checking testbench for frame_ring_queue_core: directed and random traffic,
// predicted results checked in order against every output transfer.
// Depends on frq_pkg and frame_ring_queue_core.
module frame_ring_queue_core_tb;
    import frq_pkg::*;

    localparam int SLOTS        = 16;
    localparam int SLOT_BYTES   = 2048;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 44;

    // Command code the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data_byte;
        logic              frame_last;
        logic [LEN_W-1:0]  read_limit;
        logic [SETV_W-1:0] set_value;
    } ring_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  frame_len;
        logic [OCC_W-1:0]  occupancy;
    } ring_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              slot_limit_we = 1'b0;
    logic [LEN_W-1:0]  slot_limit_wdata = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [CMD_W-1:0]  cmd = '0;
    logic [BYTE_W-1:0] data_byte = '0;
    logic              frame_last = 1'b0;
    logic [LEN_W-1:0]  read_limit = '0;
    logic [SETV_W-1:0] set_value = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  frame_len;
    logic [OCC_W-1:0]  occupancy;

    frame_ring_queue_core #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .slot_limit_we    (slot_limit_we),
        .slot_limit_wdata (slot_limit_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .data_byte        (data_byte),
        .frame_last       (frame_last),
        .read_limit       (read_limit),
        .set_value        (set_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_byte         (out_byte),
        .out_last         (out_last),
        .status           (status),
        .frame_len        (frame_len),
        .occupancy        (occupancy)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Ring state as the predictor sees it
    logic [LEN_W-1:0]  cfg_slot_limit = SLOT_LIMIT_RST;
    logic [OCC_W-1:0]  rd_slot = '0;
    logic [OCC_W-1:0]  wr_slot = '0;
    int                wr_offset = 0;
    int                rd_offset = 0;
    bit                drop_frame = 1'b0;
    bit                trunc_frame = 1'b0;
    int                slot_len [SLOTS] = '{default: 0};
    logic [BYTE_W-1:0] ring_bytes [SLOTS * SLOT_BYTES];

    ring_item_t   pending_items [$];
    ring_result_t due_results [$];
    ring_item_t   offered;
    ring_result_t oldest_due;

    int mismatch_count = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int burst_left = 1;
    int stall_mode = 0;
    int mode_left = 0;
    int stall_phase = 0;
    int hold_left = 0;
    bit long_hold_req = 1'b0;
    bit long_hold_done = 1'b0;

    function automatic logic [OCC_W-1:0] next_slot(input logic [OCC_W-1:0] s);
        return OCC_W'((int'(s) + 1) % SLOTS);
    endfunction

    // Advance the ring state by one accepted item and queue the result it causes
    function automatic void step_ring_model(input ring_item_t it);
        int           lim;
        int           len;
        int           n;
        int           idx;
        ring_result_t r;
        r = '0;
        if (it.cmd == CMD_PUSH)
        begin
            lim = int'(cfg_slot_limit);
            if (lim == 0)
                lim = 1;
            if (lim > SLOT_BYTES)
                lim = SLOT_BYTES;
            // a frame that starts against a full ring is dropped whole
            if (wr_offset == 0 && !drop_frame && !trunc_frame && next_slot(wr_slot) == rd_slot)
                drop_frame = 1'b1;
            if (!drop_frame)
            begin
                if (wr_offset < lim)
                begin
                    ring_bytes[int'(wr_slot) * SLOT_BYTES + wr_offset] = it.data_byte;
                    wr_offset++;
                end
                else
                begin
                    trunc_frame = 1'b1;
                end
            end
            if (!it.frame_last)
                return;
            if (drop_frame)
            begin
                r.status = ST_DROPPED;
            end
            else
            begin
                r.status = trunc_frame ? ST_TRUNC : ST_OK;
                r.frame_len = LEN_W'(wr_offset);
                slot_len[wr_slot] = wr_offset;
                wr_slot = next_slot(wr_slot);
            end
            drop_frame = 1'b0;
            trunc_frame = 1'b0;
            wr_offset = 0;
        end
        else if (it.cmd == CMD_POP)
        begin
            len = slot_len[rd_slot];
            if (rd_slot == wr_slot || len == 0)
            begin
                rd_offset = 0;
                r.status = ST_EMPTY;
            end
            else
            begin
                n = (it.read_limit == 0) ? 1 : int'(it.read_limit);
                if (len < n)
                    n = len;
                if (n > SLOT_BYTES)
                    n = SLOT_BYTES;
                // an offset past the count returns the last byte of the count
                idx = (rd_offset < n) ? rd_offset : n - 1;
                r.out_byte = ring_bytes[int'(rd_slot) * SLOT_BYTES + idx];
                r.frame_len = LEN_W'(len);
                r.status = ST_OK;
                if (idx + 1 >= n)
                begin
                    r.out_last = 1'b1;
                    rd_slot = next_slot(rd_slot);
                    rd_offset = 0;
                end
                else
                begin
                    rd_offset = idx + 1;
                end
            end
        end
        else if (it.cmd == CMD_SET)
        begin
            wr_slot = OCC_W'((int'(rd_slot) + int'(it.set_value) % SLOTS) % SLOTS);
            wr_offset = 0;
            drop_frame = 1'b0;
            trunc_frame = 1'b0;
            r.status = ST_OK;
        end
        else
        begin
            return;
        end
        r.occupancy = wr_slot - rd_slot;
        due_results.push_back(r);
    endfunction

    // Driver: offer pending items in bursts, hold a stalled transfer
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                step_ring_model(offered);
            if (in_valid && in_stall)
            begin
                // hold payload until the transfer completes
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                offered = pending_items.pop_front();
                cmd <= offered.cmd;
                data_byte <= offered.data_byte;
                frame_last <= offered.frame_last;
                read_limit <= offered.read_limit;
                set_value <= offered.set_value;
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= int'($urandom_range(1, 24));
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 8));
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall on a changing pattern, once for a long stretch
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (long_hold_req && !long_hold_done)
            begin
                out_stall <= 1'b1;
                hold_left <= LONG_HOLD;
                long_hold_done <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 9) < 6);
                    default: out_stall <= (stall_phase == 0);
                endcase
            end
            stall_phase <= (stall_phase == 2) ? 0 : stall_phase + 1;
            if (mode_left == 0)
            begin
                stall_mode <= int'($urandom_range(0, 3));
                mode_left <= int'($urandom_range(20, 120));
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
        end
    end

    // Monitor: compare each output transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: byte %0h last %0b st %0d len %0d occ %0d",
                             out_byte, out_last, status, frame_len, occupancy);
            end
            else
            begin
                oldest_due = due_results.pop_front();
                if (out_byte !== oldest_due.out_byte || out_last !== oldest_due.out_last ||
                    status !== oldest_due.status || frame_len !== oldest_due.frame_len ||
                    occupancy !== oldest_due.occupancy)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("result mismatch: got byte %0h last %0b st %0d len %0d occ %0d",
                                 out_byte, out_last, status, frame_len, occupancy);
                        $display("                want byte %0h last %0b st %0d len %0d occ %0d",
                                 oldest_due.out_byte, oldest_due.out_last, oldest_due.status,
                                 oldest_due.frame_len, oldest_due.occupancy);
                    end
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic add_item(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b,
                            input logic l, input logic [LEN_W-1:0] rl,
                            input logic [SETV_W-1:0] sv);
        ring_item_t it;
        it.cmd = c;
        it.data_byte = b;
        it.frame_last = l;
        it.read_limit = rl;
        it.set_value = sv;
        pending_items.push_back(it);
    endtask

    // Push a frame of random bytes; leave the last mark off for a broken frame
    task automatic add_frame(input int len, input bit closed);
        for (int i = 0; i < len; i++)
            add_item(CMD_PUSH, BYTE_W'($urandom_range(0, 255)), closed && (i == len - 1),
                     LEN_W'($urandom_range(0, 4095)), SETV_W'($urandom_range(0, 255)));
    endtask

    function automatic logic [LEN_W-1:0] pick_read_limit();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 70)
            return LEN_W'($urandom_range(1, 8));
        else if (r < 80)
            return '0;
        else if (r < 85)
            return '1;
        else if (r < 90)
            return LEN_W'(SLOT_BYTES);
        return LEN_W'($urandom_range(0, 4095));
    endfunction

    // Mostly whole frames and pop runs, with sets, broken frames and noise
    task automatic add_random_traffic(input int count);
        int               added;
        int               r;
        int               len;
        int               pops;
        logic [LEN_W-1:0] rl;
        added = 0;
        while (added < count)
        begin
            r = int'($urandom_range(0, 99));
            if (r < 45)
            begin
                len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 40))
                                                  : int'($urandom_range(1, 12));
                add_frame(len, 1'b1);
                added += len;
            end
            else if (r < 80)
            begin
                rl = pick_read_limit();
                pops = int'($urandom_range(1, 10));
                repeat (pops)
                    add_item(CMD_POP, BYTE_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), rl, SETV_W'($urandom_range(0, 255)));
                added += pops;
            end
            else if (r < 88)
            begin
                add_item(CMD_SET, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         LEN_W'($urandom_range(0, 4095)),
                         SETV_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                      : $urandom_range(0, 255)));
                added++;
            end
            else if (r < 93)
            begin
                len = int'($urandom_range(1, 5));
                add_frame(len, 1'b0);
                added += len;
            end
            else if (r < 97)
            begin
                add_item(CMD_UNUSED, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         LEN_W'($urandom_range(0, 4095)), SETV_W'($urandom_range(0, 255)));
                added++;
            end
            else
            begin
                add_item(CMD_POP, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         LEN_W'($urandom_range(0, 4095)), SETV_W'($urandom_range(0, 255)));
                added++;
            end
        end
    endtask

    // Wait until every item has transferred and every result has arrived
    task automatic wait_drained();
        @(negedge clk);
        while (pending_items.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_slot_limit(input logic [LEN_W-1:0] v);
        wait_drained();
        @(posedge clk);
        slot_limit_we <= 1'b1;
        slot_limit_wdata <= v;
        cfg_slot_limit = v;
        @(posedge clk);
        slot_limit_we <= 1'b0;
    endtask

    initial
    begin
        logic [LEN_W-1:0] limit_plan [7];
        limit_plan = '{12'd4095, 12'd1, 12'd0, 12'd5, 12'd17, 12'd2048, 12'd3};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty pop, byte extremes, ignored command, read limit of zero
        add_item(CMD_POP, 8'h00, 1'b0, 12'd5, 8'h00);
        add_item(CMD_SET, 8'h00, 1'b0, 12'd1, 8'h00);
        add_item(CMD_PUSH, 8'h00, 1'b0, 12'd0, 8'h00);
        add_item(CMD_PUSH, 8'hFF, 1'b0, 12'hFFF, 8'hFF);
        add_item(CMD_PUSH, 8'hA5, 1'b1, 12'd7, 8'h3C);
        add_item(CMD_UNUSED, 8'hFF, 1'b1, 12'hFFF, 8'hFF);
        add_item(CMD_POP, 8'h00, 1'b0, 12'd0, 8'h00);
        // one-byte frame, then a four-byte frame
        add_item(CMD_PUSH, 8'h5A, 1'b1, 12'd1, 8'h00);
        add_item(CMD_PUSH, 8'h11, 1'b0, 12'd1, 8'h00);
        add_item(CMD_PUSH, 8'h22, 1'b0, 12'd1, 8'h00);
        add_item(CMD_PUSH, 8'h33, 1'b0, 12'd1, 8'h00);
        add_item(CMD_PUSH, 8'h44, 1'b1, 12'd1, 8'h00);
        add_item(CMD_POP, 8'h00, 1'b0, 12'hFFF, 8'h00);
        // shrink the read limit below the read offset mid-frame
        add_item(CMD_POP, 8'h00, 1'b0, 12'd3, 8'h00);
        add_item(CMD_POP, 8'h00, 1'b0, 12'd1, 8'h00);
        // fill the ring by a set, then meet it with a frame
        add_item(CMD_SET, 8'h00, 1'b0, 12'd1, 8'hFF);
        add_item(CMD_PUSH, 8'h12, 1'b0, 12'd1, 8'h00);
        add_item(CMD_PUSH, 8'h34, 1'b1, 12'd1, 8'h00);
        // abandon a frame by a set that wraps to zero
        add_item(CMD_PUSH, 8'h56, 1'b0, 12'd1, 8'h00);
        add_item(CMD_SET, 8'h00, 1'b0, 12'd1, 8'h10);
        add_item(CMD_POP, 8'h00, 1'b0, 12'd2, 8'h00);
        // head slot of length zero reads empty
        add_item(CMD_SET, 8'h00, 1'b0, 12'd1, 8'h02);
        add_item(CMD_POP, 8'h00, 1'b0, 12'd2, 8'h00);
        add_item(CMD_SET, 8'h00, 1'b0, 12'd1, 8'h00);
        // pop at a read limit of SLOT_BYTES
        add_item(CMD_POP, 8'h00, 1'b0, LEN_W'(SLOT_BYTES), 8'h00);
        add_random_traffic(RANDOM_ITEMS);

        // Random phases across the slot limit range
        for (int ph = 0; ph < 7; ph++)
        begin
            write_slot_limit(limit_plan[ph]);
            if (ph == 2)
                long_hold_req = 1'b1;
            add_random_traffic(RANDOM_ITEMS);
        end

        wait_drained();
        if (mismatch_count == 0 && due_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== frame_ring_queue_core.f =====
rtl/core/frq_pkg.sv
rtl/core/frq_payload_mem.sv
rtl/core/frq_len_store.sv
rtl/core/frame_ring_queue_core.sv
sim/frame_ring_queue_core_tb.sv
